@@ design/rrva_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrva_pkg: shared definitions for the round-robin voice allocator
// Voice count, field widths and the event opcodes.
// ----------------------------------------------------------------------------
package rrva_pkg;

   // Voice count in use and the slot count that the masks are sized for
   localparam int MaxSlots = 8;
   localparam int Voices   = 8;
   localparam int SlotW    = $clog2(MaxSlots);
   localparam int CountW   = $clog2(Voices) + 1;

   localparam int KeyW = 7;
   localparam int VelW = 7;
   localparam int OpW  = 2;

   // Mask with one bit set per voice in use
   localparam logic [MaxSlots-1:0] AllVoices = {MaxSlots{1'b1}} >> (MaxSlots - Voices);

   typedef enum logic [OpW-1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_ALL_OFF  = 2'd2
   } op_type;

   typedef logic [SlotW-1:0] slot_type;
   typedef logic [KeyW-1:0]  key_type;

   // Next voice in round-robin order
   function automatic slot_type next_slot(input slot_type s);
      slot_type r;
      if (int'(s) == Voices - 1) begin
         r = '0;
      end else begin
         r = s + slot_type'(1);
      end
      return r;
   endfunction

endpackage

@@ design/round_robin_voice_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_voice_allocator_unit: polyphonic voice allocator
// Assigns note-on events to idle voices in round-robin order, steals the
// voice at the pointer when all are sounding, and builds release masks for
// note-off and all-notes-off events.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A note on
// examines one voice per cycle with a single mask test, starting at the
// round-robin pointer, until an idle voice is found or all are tested; a
// note off (or note on with zero velocity) compares the key against each
// stored voice key with one shared comparator. All notes off and the unused
// opcode finish at once. The result appears on the rsp_ ports for one cycle
// marked by rsp_valid, in the cycle in which busy falls, and must be captured
// then: the receiver cannot stall the block.
module round_robin_voice_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rrva_pkg::OpW-1:0]      req_op,
   input  logic [rrva_pkg::KeyW-1:0]     req_key,
   input  logic [rrva_pkg::VelW-1:0]     req_velocity,
   input  logic [rrva_pkg::MaxSlots-1:0] req_active_mask,
   output logic                          rsp_valid,
   output logic                          rsp_started,
   output logic [rrva_pkg::SlotW-1:0]    rsp_voice_slot,
   output logic                          rsp_stolen,
   output logic [rrva_pkg::KeyW-1:0]     rsp_note_key,
   output logic [rrva_pkg::VelW-1:0]     rsp_note_velocity,
   output logic [rrva_pkg::MaxSlots-1:0] rsp_release_mask
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_RELEASE
   } state_type;

   state_type                    state_ff, state_in;
   rrva_pkg::slot_type           ptr_ff, ptr_in;
   rrva_pkg::key_type            keys_ff [rrva_pkg::MaxSlots];
   rrva_pkg::key_type            keys_in [rrva_pkg::MaxSlots];
   rrva_pkg::slot_type           idx_ff, idx_in;
   logic [rrva_pkg::CountW-1:0]  count_ff, count_in;
   rrva_pkg::key_type            key_ff, key_in;
   logic [rrva_pkg::VelW-1:0]    vel_ff, vel_in;
   logic [rrva_pkg::MaxSlots-1:0] act_ff, act_in;
   logic [rrva_pkg::MaxSlots-1:0] rel_ff, rel_in;

   logic                          valid_ff, valid_in;
   logic                          started_ff, started_in;
   rrva_pkg::slot_type            slot_ff, slot_in;
   logic                          stolen_ff, stolen_in;
   rrva_pkg::key_type             nkey_ff, nkey_in;
   logic [rrva_pkg::VelW-1:0]     nvel_ff, nvel_in;
   logic [rrva_pkg::MaxSlots-1:0] relmask_ff, relmask_in;

   logic accept;
   logic last_voice;
   logic key_hit;

   assign accept     = start && (state_ff == ST_IDLE);
   assign last_voice = (count_ff == rrva_pkg::CountW'(rrva_pkg::Voices - 1));
   // Shared key comparator on the voice under examination
   assign key_hit    = (keys_ff[idx_ff] == key_ff);

   // Sequence the scan and build the next state
   always_comb begin
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      keys_in    = keys_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      key_in     = key_ff;
      vel_in     = vel_ff;
      act_in     = act_ff;
      rel_in     = rel_ff;
      valid_in   = 1'b0;
      started_in = started_ff;
      slot_in    = slot_ff;
      stolen_in  = stolen_ff;
      nkey_in    = nkey_ff;
      nvel_in    = nvel_ff;
      relmask_in = relmask_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = req_key;
               vel_in   = req_velocity;
               act_in   = req_active_mask;
               idx_in   = ptr_ff;
               count_in = '0;
               rel_in   = '0;
               case (req_op)
                  rrva_pkg::OP_NOTE_ON: begin
                     if (req_velocity != '0) begin
                        state_in = ST_ALLOC;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_RELEASE;
                     end
                  end
                  rrva_pkg::OP_NOTE_OFF: begin
                     idx_in   = '0;
                     state_in = ST_RELEASE;
                  end
                  rrva_pkg::OP_ALL_OFF: begin
                     valid_in   = 1'b1;
                     started_in = 1'b0;
                     slot_in    = '0;
                     stolen_in  = 1'b0;
                     nkey_in    = '0;
                     nvel_in    = '0;
                     relmask_in = rrva_pkg::AllVoices;
                  end
                  default: begin
                     // Unused opcode: report an empty result
                     valid_in   = 1'b1;
                     started_in = 1'b0;
                     slot_in    = '0;
                     stolen_in  = 1'b0;
                     nkey_in    = '0;
                     nvel_in    = '0;
                     relmask_in = '0;
                  end
               endcase
            end
         end

         ST_ALLOC: begin
            // Test one voice per cycle; take the first idle one, else steal
            if (!act_ff[idx_ff] || last_voice) begin
               valid_in   = 1'b1;
               started_in = 1'b1;
               nkey_in    = key_ff;
               nvel_in    = vel_ff;
               relmask_in = '0;
               state_in   = ST_IDLE;
               if (!act_ff[idx_ff]) begin
                  slot_in         = idx_ff;
                  stolen_in       = 1'b0;
                  keys_in[idx_ff] = key_ff;
                  ptr_in          = rrva_pkg::next_slot(ptr_ff);
               end else begin
                  slot_in         = ptr_ff;
                  stolen_in       = 1'b1;
                  keys_in[ptr_ff] = key_ff;
               end
            end else begin
               idx_in   = rrva_pkg::next_slot(idx_ff);
               count_in = count_ff + rrva_pkg::CountW'(1);
            end
         end

         ST_RELEASE: begin
            // Compare one stored key per cycle and collect the matches
            rel_in[idx_ff] = key_hit;
            if (last_voice) begin
               valid_in       = 1'b1;
               started_in     = 1'b0;
               slot_in        = '0;
               stolen_in      = 1'b0;
               nkey_in        = '0;
               nvel_in        = '0;
               relmask_in     = rel_ff;
               relmask_in[idx_ff] = key_hit;
               state_in       = ST_IDLE;
            end else begin
               idx_in   = rrva_pkg::next_slot(idx_ff);
               count_in = count_ff + rrva_pkg::CountW'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, voice keys and the registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
         valid_ff <= 1'b0;
         for (int v = 0; v < rrva_pkg::MaxSlots; v++) begin
            keys_ff[v] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
         keys_ff  <= keys_in;
      end
      idx_ff     <= idx_in;
      count_ff   <= count_in;
      key_ff     <= key_in;
      vel_ff     <= vel_in;
      act_ff     <= act_in;
      rel_ff     <= rel_in;
      started_ff <= started_in;
      slot_ff    <= slot_in;
      stolen_ff  <= stolen_in;
      nkey_ff    <= nkey_in;
      nvel_ff    <= nvel_in;
      relmask_ff <= relmask_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_started       = started_ff;
   assign rsp_voice_slot    = slot_ff;
   assign rsp_stolen        = stolen_ff;
   assign rsp_note_key      = nkey_ff;
   assign rsp_note_velocity = nvel_ff;
   assign rsp_release_mask  = relmask_ff;

   // A result is never shown while a scan is still running
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Every accepted transaction either starts a scan or reports at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction dropped");

   // A steal is only reported for a started voice, and a start releases nothing
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_started) |-> (rsp_release_mask == '0))
      else $error("release mask set on a note start");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stolen) |-> (rsp_started && rsp_voice_slot == $past(ptr_ff)))
      else $error("steal not at the round-robin pointer");

endmodule
